// File: src/bst_pkg.sv
`timescale 1ns / 1ps
package bst_pkg;

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_COMMENT = 4'd1;
  localparam logic [3:0] M_SLASH   = 4'd2;
  localparam logic [3:0] M_INT     = 4'd3;
  localparam logic [3:0] M_INTDOT  = 4'd4;
  localparam logic [3:0] M_REAL    = 4'd5;
  localparam logic [3:0] M_IDENT   = 4'd6;
  localparam logic [3:0] M_EQ      = 4'd7;
  localparam logic [3:0] M_DOT     = 4'd8;
  localparam logic [3:0] M_CROSS1  = 4'd9;
  localparam logic [3:0] M_INTER1  = 4'd10;
  localparam logic [3:0] M_INTER2  = 4'd11;

  localparam logic [4:0] K_EOF = 5'd0, K_INT = 5'd1, K_REAL = 5'd2, K_IDENT = 5'd3;
  localparam logic [4:0] K_PLUS = 5'd4, K_MINUS = 5'd5, K_STAR = 5'd6, K_SLASH = 5'd7;
  localparam logic [4:0] K_CARET = 5'd8, K_CROSS = 5'd9, K_INTER = 5'd10;
  localparam logic [4:0] K_LPAREN = 5'd11, K_RPAREN = 5'd12, K_LBRACE = 5'd13;
  localparam logic [4:0] K_RBRACE = 5'd14, K_LBRACKET = 5'd15, K_RBRACKET = 5'd16;
  localparam logic [4:0] K_COMMA = 5'd17, K_DOTDOT = 5'd18, K_EQ = 5'd19;
  localparam logic [4:0] K_ARROW = 5'd20, K_LET = 5'd21, K_IN = 5'd22, K_FN = 5'd23;
  localparam logic [4:0] K_PRINT = 5'd24, K_ERROR = 5'd25;

  localparam logic [62:0] MAX63 = {63{1'b1}};
  localparam logic [39:0] W_LET   = 40'h6C6574;
  localparam logic [39:0] W_IN    = 40'h696E;
  localparam logic [39:0] W_FN    = 40'h666E;
  localparam logic [39:0] W_PRINT = 40'h7072696E74;

  // One token as carried between the scanner and the output queue.
  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] start;
    logic [31:0] len;
    logic [31:0] line;
    logic [62:0] ival;
    logic [59:0] fval;
    logic [4:0]  fcnt;
  } tok_t;

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
           b == 8'h5F || is_digit(b);
  endfunction

  function automatic logic [4:0] single_kind(input logic [7:0] b);
    logic [4:0] k;
    unique case (b)
      8'h2B: k = K_PLUS;
      8'h2D: k = K_MINUS;
      8'h2A: k = K_STAR;
      8'h5E: k = K_CARET;
      8'h28: k = K_LPAREN;
      8'h29: k = K_RPAREN;
      8'h7B: k = K_LBRACE;
      8'h7D: k = K_RBRACE;
      8'h5B: k = K_LBRACKET;
      8'h5D: k = K_RBRACKET;
      8'h2C: k = K_COMMA;
      default: k = K_ERROR;
    endcase
    return k;
  endfunction

endpackage

// File: src/bst_scan.sv
`timescale 1ns / 1ps
// Per-byte scanner: state registers and the tokens one byte produces.
module bst_scan import bst_pkg::*; #(
  parameter int POS_BITS  = 32,
  parameter int LINE_BITS = 32,
  parameter int FRAC_KEEP = 18
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] text_byte,
  input  logic       end_flag,
  output tok_t       tok [3],
  output logic [1:0] tok_n_m1,
  output logic       tok_any
);

  localparam logic [POS_BITS-1:0]  PMAX = {POS_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0] LMAX = {LINE_BITS{1'b1}};

  logic [3:0]           mode_r, mode_nxt;
  logic [POS_BITS-1:0]  pstart_r, pstart_nxt, pos_r, pos_nxt, wlen_r, wlen_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic [62:0]          num_r, num_nxt;
  logic [59:0]          frac_r, frac_nxt;
  logic [4:0]           fdig_r, fdig_nxt;
  logic [39:0]          wpre_r, wpre_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; pstart_r <= '0; pos_r <= '0; line_r <= LINE_BITS'(1);
      num_r <= '0; frac_r <= '0; fdig_r <= '0; wpre_r <= '0; wlen_r <= '0;
    end else if (step) begin
      mode_r <= mode_nxt; pstart_r <= pstart_nxt; pos_r <= pos_nxt;
      line_r <= line_nxt; num_r <= num_nxt; frac_r <= frac_nxt;
      fdig_r <= fdig_nxt; wpre_r <= wpre_nxt; wlen_r <= wlen_nxt;
    end
  end

  logic [7:0]  b;
  logic [3:0]  dg;
  logic [66:0] num_x10;
  logic [62:0] num_add;
  logic [63:0] frac_x10;
  logic [POS_BITS-1:0] prev, wlen_p1, wlen_p2;
  logic [4:0]  wkind;
  logic [31:0] pos32, prev32, pstart32, wlen32;
  logic [31:0] line32;

  assign b = text_byte;
  assign dg = b[3:0];
  assign num_x10 = {4'd0, num_r} * 67'd10 + 67'(dg);
  assign num_add = (num_x10 > 67'(MAX63)) ? MAX63 : num_x10[62:0];
  assign frac_x10 = {4'd0, frac_r} * 64'd10 + 64'(dg);
  assign prev = (pos_r == '0) ? '0 : pos_r - 1'b1;
  assign wlen_p1 = (wlen_r == PMAX) ? PMAX : wlen_r + 1'b1;
  assign wlen_p2 = (wlen_r >= PMAX - 1'b1) ? PMAX : wlen_r + POS_BITS'(2);
  assign pos32 = 32'(pos_r);
  assign prev32 = 32'(prev);
  assign pstart32 = 32'(pstart_r);
  assign wlen32 = 32'(wlen_r);

  always_comb begin
    priority if (wlen_r == POS_BITS'(3) && wpre_r == W_LET) wkind = K_LET;
    else if (wlen_r == POS_BITS'(2) && wpre_r == W_IN) wkind = K_IN;
    else if (wlen_r == POS_BITS'(2) && wpre_r == W_FN) wkind = K_FN;
    else if (wlen_r == POS_BITS'(5) && wpre_r == W_PRINT) wkind = K_PRINT;
    else wkind = K_IDENT;
  end

  logic [1:0] n;
  logic       close, fresh;

  always_comb begin
    tok_t t;
    mode_nxt = mode_r; pstart_nxt = pstart_r; line_nxt = line_r;
    num_nxt = num_r; frac_nxt = frac_r; fdig_nxt = fdig_r;
    wpre_nxt = wpre_r; wlen_nxt = wlen_r;
    pos_nxt = (pos_r == PMAX) ? PMAX : pos_r + 1'b1;
    line32 = 32'(line_r);
    // every token carries the line as it stood before this byte
    t = '{kind: K_EOF, start: '0, len: '0, line: line32, ival: '0, fval: '0, fcnt: '0};
    for (int i = 0; i < 3; i++) tok[i] = t;
    n = 2'd0; close = 1'b0; fresh = 1'b0;

    if (end_flag) begin
      close = 1'b1;
    end else begin
      unique case (mode_r)
        M_COMMENT: fresh = (b == 8'h0A);
        M_SLASH: if (b == 8'h2F) mode_nxt = M_COMMENT; else close = 1'b1;
        M_INT: begin
          if (is_digit(b)) begin
            num_nxt = num_add; wlen_nxt = wlen_p1;
          end else if (b == 8'h2E) mode_nxt = M_INTDOT;
          else close = 1'b1;
        end
        M_INTDOT: begin
          if (is_digit(b)) begin
            mode_nxt = M_REAL; wlen_nxt = wlen_p2;
            if (fdig_r < 5'(FRAC_KEEP)) begin
              frac_nxt = frac_x10[59:0]; fdig_nxt = fdig_r + 1'b1;
            end
          end else begin
            tok[0].kind = K_INT; tok[0].start = pstart32; tok[0].len = wlen32;
            tok[0].ival = num_r;
            n = 2'd2;
            if (b == 8'h2E) begin
              tok[1].kind = K_DOTDOT; tok[1].start = prev32; tok[1].len = 32'd2;
              mode_nxt = M_IDLE;
            end else begin
              tok[1].kind = K_ERROR; tok[1].start = prev32; tok[1].len = 32'd1;
              fresh = 1'b1;
            end
          end
        end
        M_REAL: begin
          if (is_digit(b)) begin
            wlen_nxt = wlen_p1;
            if (fdig_r < 5'(FRAC_KEEP)) begin
              frac_nxt = frac_x10[59:0]; fdig_nxt = fdig_r + 1'b1;
            end
          end else close = 1'b1;
        end
        M_IDENT: begin
          if (is_word(b)) begin
            if (wlen_r < POS_BITS'(5)) wpre_nxt = {wpre_r[31:0], b};
            wlen_nxt = wlen_p1;
          end else close = 1'b1;
        end
        M_EQ, M_DOT, M_CROSS1, M_INTER2: begin
          if ((mode_r == M_EQ && b == 8'h3E) || (mode_r == M_DOT && b == 8'h2E) ||
              (mode_r == M_CROSS1 && b == 8'h97) || (mode_r == M_INTER2 && b == 8'hA9)) begin
            unique case (mode_r)
              M_EQ:     begin tok[0].kind = K_ARROW;  tok[0].len = 32'd2; end
              M_DOT:    begin tok[0].kind = K_DOTDOT; tok[0].len = 32'd2; end
              M_CROSS1: begin tok[0].kind = K_CROSS;  tok[0].len = 32'd2; end
              default:  begin tok[0].kind = K_INTER;  tok[0].len = 32'd3; end
            endcase
            tok[0].start = pstart32; n = 2'd1; mode_nxt = M_IDLE;
          end else close = 1'b1;
        end
        M_INTER1: if (b == 8'h88) mode_nxt = M_INTER2; else close = 1'b1;
        default: fresh = 1'b1;
      endcase
    end

    if (close) begin
      unique case (mode_r)
        M_SLASH, M_EQ: begin
          tok[0].kind = (mode_r == M_SLASH) ? K_SLASH : K_EQ;
          tok[0].start = pstart32; tok[0].len = 32'd1; n = 2'd1;
        end
        M_INT, M_INTDOT, M_REAL: begin
          tok[0].kind = (mode_r == M_REAL) ? K_REAL : K_INT;
          tok[0].start = pstart32; tok[0].len = wlen32; tok[0].ival = num_r;
          if (mode_r == M_REAL) begin
            tok[0].fval = frac_r; tok[0].fcnt = fdig_r;
          end
          n = 2'd1;
          if (mode_r == M_INTDOT) begin
            tok[1].kind = K_ERROR; tok[1].start = prev32; tok[1].len = 32'd1; n = 2'd2;
          end
        end
        M_IDENT: begin
          tok[0].kind = wkind; tok[0].start = pstart32; tok[0].len = wlen32; n = 2'd1;
        end
        M_DOT, M_CROSS1, M_INTER1, M_INTER2: begin
          tok[0].kind = K_ERROR; tok[0].start = pstart32; tok[0].len = 32'd1; n = 2'd1;
          if (mode_r == M_INTER2) begin
            tok[1].kind = K_ERROR; tok[1].start = prev32; tok[1].len = 32'd1; n = 2'd2;
          end
        end
        default: ;
      endcase
      fresh = !end_flag;
      mode_nxt = M_IDLE;
    end

    if (end_flag) begin
      tok[n].kind = K_EOF; tok[n].start = pos32; tok[n].len = '0;
      n = n + 1'b1;
      mode_nxt = M_IDLE; pstart_nxt = '0; pos_nxt = '0; line_nxt = LINE_BITS'(1);
      num_nxt = '0; frac_nxt = '0; fdig_nxt = '0; wpre_nxt = '0; wlen_nxt = '0;
    end else if (fresh) begin
      pstart_nxt = pos_r; wlen_nxt = POS_BITS'(1);
      num_nxt = '0; frac_nxt = '0; fdig_nxt = '0; wpre_nxt = '0;
      mode_nxt = M_IDLE;
      if (b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A) begin
        if (b == 8'h0A) line_nxt = (line_r == LMAX) ? LMAX : line_r + 1'b1;
      end else if (is_digit(b)) begin
        mode_nxt = M_INT; num_nxt = 63'(dg);
      end else if (is_word(b)) begin
        mode_nxt = M_IDENT; wpre_nxt = 40'(b);
      end else if (b == 8'h2F) mode_nxt = M_SLASH;
      else if (b == 8'h3D) mode_nxt = M_EQ;
      else if (b == 8'h2E) mode_nxt = M_DOT;
      else if (b == 8'hC3) mode_nxt = M_CROSS1;
      else if (b == 8'hE2) mode_nxt = M_INTER1;
      else begin
        tok[n].kind = single_kind(b); tok[n].start = pos32; tok[n].len = 32'd1;
        n = n + 1'b1;
      end
    end
  end

  assign tok_any  = (n != 2'd0);
  assign tok_n_m1 = n - 1'b1;

endmodule

// File: src/byte_stream_tokenizer_unit.sv
`timescale 1ns / 1ps
// Streaming tokenizer: one source byte per request on the in_ channel,
// tokens on the out_ channel.
// A byte may produce zero to three tokens; out_last_of_run marks the last.
// Input side takes one byte per cycle while the output queue has room for
// three tokens. The tokens of an accepted byte are written into the output queue
// registers and leave from there. Throughput: one byte per cycle while each byte
// yields at most one token and out_ready is high; a byte that yields several
// tokens drains through the single-token output port, one token per pop.
// Stall: when out_ready is low the queue fills and in_ready drops once fewer
// than three free slots remain; nothing is lost.
// An end flag or a zero byte closes the pending token, emits EOF and
// returns position and line count to their start values.
// Reset (rst_n low, synchronous) empties the queue and sets line to 1.
module byte_stream_tokenizer_unit import bst_pkg::*; #(
  parameter int POS_BITS  = 32,
  parameter int LINE_BITS = 32,
  parameter int FRAC_KEEP = 18
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_token_kind,
  output logic [31:0] out_start_pos,
  output logic [31:0] out_token_length,
  output logic [31:0] out_line_number,
  output logic [62:0] out_int_value,
  output logic [59:0] out_frac_value,
  output logic [4:0]  out_frac_count,
  output logic        out_last_of_run
);

  localparam int QD = 8;

  logic       step;
  tok_t       tok [3];
  logic [1:0] tok_n_m1;
  logic       tok_any;

  assign step = in_valid && in_ready;

  bst_scan #(.POS_BITS(POS_BITS), .LINE_BITS(LINE_BITS), .FRAC_KEEP(FRAC_KEEP)) u_scan (
    .clk, .rst_n, .step,
    .text_byte(in_text_byte),
    .end_flag(in_end_of_text || in_text_byte == 8'h00),
    .tok, .tok_n_m1, .tok_any
  );

  tok_t       q_r [QD];
  logic       ql_r [QD];
  logic [2:0] wp_r, rp_r;
  logic [3:0] cnt_r, cnt_nxt;
  logic       pop;
  logic [1:0] push_n;

  assign pop    = out_valid && out_ready;
  assign push_n = (step && tok_any) ? tok_n_m1 + 1'b1 : 2'd0;
  assign cnt_nxt = cnt_r + 4'(push_n) - 4'(pop);
  assign in_ready = (cnt_r <= 4'(QD - 3));
  assign out_valid = (cnt_r != 4'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_r + 3'(push_n);
      rp_r <= rp_r + 3'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_n) begin
        q_r[wp_r + 3'(i)]  <= tok[i];
        ql_r[wp_r + 3'(i)] <= (2'(i) == tok_n_m1);
      end
    end
  end

  assign out_token_kind   = q_r[rp_r].kind;
  assign out_start_pos    = q_r[rp_r].start;
  assign out_token_length = q_r[rp_r].len;
  assign out_line_number  = q_r[rp_r].line;
  assign out_int_value    = q_r[rp_r].ival;
  assign out_frac_value   = q_r[rp_r].fval;
  assign out_frac_count   = q_r[rp_r].fcnt;
  assign out_last_of_run  = ql_r[rp_r];

endmodule

// File: src/bst_checker.sv
`timescale 1ns / 1ps
module bst_checker import bst_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] out_token_kind,
  input logic [31:0] out_token_length,
  input logic       out_last_of_run
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_kind))
    else $error("output request dropped while stalled");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == K_EOF |-> out_last_of_run && out_token_length == 32'd0)
    else $error("eof token not last or nonzero length");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_token_kind <= K_ERROR)
    else $error("token kind out of range");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // an empty queue always has room for a request
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while output empty");

endmodule

bind byte_stream_tokenizer_unit bst_checker u_bst_checker (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready,
  .out_token_kind, .out_token_length, .out_last_of_run
);
